### sv/tgv_pkg.sv
// shared types, constants and helpers for the torus grid vertex and face generator
package tgv_pkg;

	localparam int unsigned MAX_RES_DEF   = 256;
	localparam int unsigned TRIG_FRAC_DEF = 14;

	localparam int unsigned IDX_W = 8;
	localparam int unsigned RES_W = 9;
	localparam int unsigned RAD_W = 16;
	localparam int unsigned POS_W = 18;
	localparam int unsigned PH_W  = 32;

	// divider: quotient bits resolved per pipeline stage
	localparam int unsigned DIV_BITS   = 4;
	localparam int unsigned DIV_STAGES = PH_W / DIV_BITS;

	// sine/cosine pipeline depth
	localparam int unsigned SC_LAT = 12;

	// register map
	typedef enum logic [2:0] {
		REG_MODE,
		REG_MAJOR,
		REG_MINOR,
		REG_RES_U,
		REG_RES_V
	} reg_idx_t;

	typedef enum logic {
		MODE_TORUS = 1'b0,
		MODE_PLANE = 1'b1
	} mode_t;

	localparam logic [RAD_W-1:0] MAJOR_RST = 16'd512;
	localparam logic [RAD_W-1:0] MINOR_RST = 16'd128;
	localparam logic [RES_W-1:0] RES_RST   = 9'd16;

	// q30 constants
	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
	localparam logic [29:0] HALF_Q30    = 30'h2000_0000;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

	// exact floor division by small constants: floor(n*m / 2^(30+l)) for n < 2^30
	localparam int unsigned L72 = 7;
	localparam int unsigned L42 = 6;
	localparam int unsigned L20 = 5;
	localparam int unsigned L6  = 3;
	localparam int unsigned L56 = 6;
	localparam int unsigned L30 = 5;
	localparam int unsigned L12 = 4;
	localparam logic [30:0] M72 = 31'(((64'd1 << (30 + L72)) / 72) + 1);
	localparam logic [30:0] M42 = 31'(((64'd1 << (30 + L42)) / 42) + 1);
	localparam logic [30:0] M20 = 31'(((64'd1 << (30 + L20)) / 20) + 1);
	localparam logic [30:0] M6  = 31'(((64'd1 << (30 + L6)) / 6) + 1);
	localparam logic [30:0] M56 = 31'(((64'd1 << (30 + L56)) / 56) + 1);
	localparam logic [30:0] M30 = 31'(((64'd1 << (30 + L30)) / 30) + 1);
	localparam logic [30:0] M12 = 31'(((64'd1 << (30 + L12)) / 12) + 1);

	localparam logic signed [20:0] POS_MAX = 21'sd131071;
	localparam logic signed [20:0] POS_MIN = -21'sd131072;

	typedef struct packed {
		logic              in_range;
		logic              faces;
		logic [IDX_W-1:0]  col;
		logic [IDX_W-1:0]  row;
		logic [15:0]       vidx;
		logic [15:0]       c_nc;
		logic [15:0]       c_nr;
		logic [15:0]       c_dg;
	} tgv_side_t;

	function automatic logic [29:0] q30_mul(input logic [29:0] a, input logic [30:0] b);
		logic [60:0] p;
		p = 61'(a) * 61'(b);
		return p[59:30];
	endfunction

	function automatic logic [29:0] cdiv(input logic [29:0] n, input logic [30:0] m,
		input int unsigned l);
		logic [60:0] p;
		p = 61'(n) * 61'(m);
		return 30'(p >> (30 + l));
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [20:0] v);
		logic signed [POS_W-1:0] r;
		if (v > POS_MAX) begin
			r = POS_MAX[POS_W-1:0];
		end else if (v < POS_MIN) begin
			r = POS_MIN[POS_W-1:0];
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

endpackage

### sv/tgv_phase_div.sv
// pipelined restoring divider giving floor(num * 2^32 / den) for num < den
module tgv_phase_div
	import tgv_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [IDX_W-1:0] num,
	input  logic [RES_W-1:0] den,
	output logic [PH_W-1:0]  quo
);

	typedef struct packed {
		logic [RES_W-1:0] rem;
		logic [PH_W-1:0]  quo;
	} div_st_t;

	div_st_t nxt [1:DIV_STAGES];
	div_st_t st_s [1:DIV_STAGES];

	function automatic div_st_t div_step(input div_st_t a, input logic [RES_W-1:0] d);
		div_st_t     o;
		logic [RES_W:0] r2;
		o = a;
		for (int i = 0; i < DIV_BITS; i++) begin
			r2 = {o.rem, 1'b0};
			if (r2 >= {1'b0, d}) begin
				r2 = r2 - {1'b0, d};
				o.quo = {o.quo[PH_W-2:0], 1'b1};
			end else begin
				o.quo = {o.quo[PH_W-2:0], 1'b0};
			end
			o.rem = r2[RES_W-1:0];
		end
		return o;
	endfunction

	always_comb begin
		nxt[1] = div_step('{rem: RES_W'(num), quo: '0}, den);
		for (int k = 2; k <= DIV_STAGES; k++) begin
			nxt[k] = div_step(st_s[k-1], den);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k <= DIV_STAGES; k++) begin
				st_s[k] <= nxt[k];
			end
		end
	end

	assign quo = st_s[DIV_STAGES].quo;

endmodule

### sv/tgv_sincos.sv
// pipelined sine and cosine of a 32-bit turn fraction, octant fold plus series
module tgv_sincos
	import tgv_pkg::*;
#(
	parameter int unsigned TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic [PH_W-1:0]                 ph,
	output logic signed [TRIG_FRAC_BITS+1:0] sn,
	output logic signed [TRIG_FRAC_BITS+1:0] cs
);

	localparam int unsigned SH   = 30 - TRIG_FRAC_BITS;
	localparam int unsigned SR_W = TRIG_FRAC_BITS + 1;
	localparam int unsigned SO_W = TRIG_FRAC_BITS + 2;
	localparam logic [30:0] RND  = 31'(1) << (SH - 1);

	logic [1:0]  q_s  [1:11];
	logic        sw_s [1:11];
	logic [29:0] r_s1;
	logic [29:0] x_s  [2:10];
	logic [29:0] x2_s [3:8];
	logic [29:0] as_s4, ac_s4, ps_s5, pc_s5, as_s6, ac_s6, ps_s7, pc_s7;
	logic [29:0] as_s8, ac_s8, ps_s9, pc_s9, as_s10, s_s11;
	logic [30:0] c_s10, c_s11;

	// octant fold
	logic [29:0] r_raw, r_fold;
	logic        sw_fold;

	// output rounding and quadrant signs
	logic [30:0]          s_add, c_add;
	logic [SR_W-1:0]      s_rnd, c_rnd, s_sel, c_sel;
	logic signed [SO_W-1:0] sq, cq, sn_d, cs_d;

	always_comb begin
		r_raw   = ph[29:0];
		sw_fold = (r_raw > HALF_Q30);
		r_fold  = sw_fold ? 30'(ONE_Q30 - 31'(r_raw)) : r_raw;
	end

	always_comb begin
		s_add = 31'(s_s11) + RND;
		c_add = c_s11 + RND;
		s_rnd = SR_W'(s_add >> SH);
		c_rnd = SR_W'(c_add >> SH);
		s_sel = sw_s[11] ? c_rnd : s_rnd;
		c_sel = sw_s[11] ? s_rnd : c_rnd;
		sq    = $signed({1'b0, s_sel});
		cq    = $signed({1'b0, c_sel});
		case (q_s[11])
			2'd0: begin
				sn_d = sq;
				cs_d = cq;
			end
			2'd1: begin
				sn_d = cq;
				cs_d = -sq;
			end
			2'd2: begin
				sn_d = -sq;
				cs_d = -cq;
			end
			default: begin
				sn_d = -cq;
				cs_d = sq;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s[1]  <= ph[31:30];
			sw_s[1] <= sw_fold;
			r_s1    <= r_fold;
			for (int k = 2; k <= 11; k++) begin
				q_s[k]  <= q_s[k-1];
				sw_s[k] <= sw_s[k-1];
			end
			x_s[2] <= q30_mul(r_s1, HALF_PI_Q30);
			for (int k = 3; k <= 10; k++) begin
				x_s[k] <= x_s[k-1];
			end
			x2_s[3] <= q30_mul(x_s[2], 31'(x_s[2]));
			for (int k = 4; k <= 8; k++) begin
				x2_s[k] <= x2_s[k-1];
			end
			// sine runs to the x^9 term, cosine to the x^8 term
			as_s4  <= cdiv(x2_s[3], M72, L72);
			ac_s4  <= cdiv(x2_s[3], M56, L56);
			ps_s5  <= q30_mul(x2_s[4], ONE_Q30 - 31'(as_s4));
			pc_s5  <= q30_mul(x2_s[4], ONE_Q30 - 31'(ac_s4));
			as_s6  <= cdiv(ps_s5, M42, L42);
			ac_s6  <= cdiv(pc_s5, M30, L30);
			ps_s7  <= q30_mul(x2_s[6], ONE_Q30 - 31'(as_s6));
			pc_s7  <= q30_mul(x2_s[6], ONE_Q30 - 31'(ac_s6));
			as_s8  <= cdiv(ps_s7, M20, L20);
			ac_s8  <= cdiv(pc_s7, M12, L12);
			ps_s9  <= q30_mul(x2_s[8], ONE_Q30 - 31'(as_s8));
			pc_s9  <= q30_mul(x2_s[8], ONE_Q30 - 31'(ac_s8));
			as_s10 <= cdiv(ps_s9, M6, L6);
			c_s10  <= ONE_Q30 - 31'(pc_s9 >> 1);
			s_s11  <= q30_mul(x_s[10], ONE_Q30 - 31'(as_s10));
			c_s11  <= c_s10;
			sn     <= sn_d;
			cs     <= cs_d;
		end
	end

endmodule

### sv/torus_grid_vertex_and_face_gen_unit.sv
// top level: torus / plane grid point to vertex, texture and quad corner generator
//
// channel   direction  handshake                 payload
// in        to block   in_valid / in_stall       col_index, row_index
// out       from block out_valid / out_stall     in_range .. corner_diagonal
// config    to block   apb psel/penable/pwrite   paddr, pwdata, prdata
//
// one transaction per cycle while the output is not stalled; at the default settings the
// pipe has 1 input stage, 8 divider stages (4 quotient bits each), 12 sine/cosine
// stages, and 4 stages for ring radius, position products and output rounding
// a stalled output holds the whole pipeline; in_stall is raised only then
// reset clears the valid bits and returns the configuration registers to their defaults
module torus_grid_vertex_and_face_gen_unit
	import tgv_pkg::*;
#(
	parameter int unsigned MAX_RES        = MAX_RES_DEF,
	parameter int unsigned TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// item input
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [IDX_W-1:0]        col_index,
	input  logic [IDX_W-1:0]        row_index,
	// result output
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    in_range,
	output logic [15:0]             vertex_index,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic signed [POS_W-1:0] pos_z,
	output logic [15:0]             tex_u,
	output logic [15:0]             tex_v,
	output logic                    faces_valid,
	output logic [15:0]             corner_here,
	output logic [15:0]             corner_next_col,
	output logic [15:0]             corner_next_row,
	output logic [15:0]             corner_diagonal,
	// configuration
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [4:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int unsigned T     = TRIG_FRAC_BITS;
	localparam int unsigned SO_W  = T + 2;
	localparam int unsigned RF_W  = T + 19;
	localparam int unsigned PX_W  = T + 21;
	// stage numbers along the pipe
	localparam int unsigned P_DIV = 1 + DIV_STAGES;
	localparam int unsigned P_SC  = P_DIV + SC_LAT;
	localparam int unsigned F1    = P_SC + 1;
	localparam int unsigned F2    = P_SC + 2;
	localparam int unsigned F3    = P_SC + 3;
	localparam int unsigned F4    = P_SC + 4;
	localparam logic [RES_W-1:0] RES_CAP = RES_W'(MAX_RES);
	localparam logic signed [RF_W-1:0] RF_HALF = RF_W'(1) << (T - 1);
	localparam logic signed [PX_W-1:0] PX_HALF = PX_W'(1) << (T - 1);

	// configuration registers
	mode_t            mode_q;
	logic [RAD_W-1:0] major_q, minor_q;
	logic [RES_W-1:0] res_u_q, res_v_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_TORUS;
			major_q <= MAJOR_RST;
			minor_q <= MINOR_RST;
			res_u_q <= RES_RST;
			res_v_q <= RES_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_MODE:  mode_q  <= mode_t'(pwdata[0]);
				REG_MAJOR: major_q <= pwdata[RAD_W-1:0];
				REG_MINOR: minor_q <= pwdata[RAD_W-1:0];
				REG_RES_U: res_u_q <= pwdata[RES_W-1:0];
				REG_RES_V: res_v_q <= pwdata[RES_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_MODE:  prdata = {31'd0, mode_q};
			REG_MAJOR: prdata = 32'(major_q);
			REG_MINOR: prdata = 32'(minor_q);
			REG_RES_U: prdata = 32'(res_u_q);
			REG_RES_V: prdata = 32'(res_v_q);
			default:   prdata = '0;
		endcase
	end

	// resolutions above the supported maximum act as the maximum
	logic [RES_W-1:0] ru, rv;
	assign ru = (32'(res_u_q) > 32'(MAX_RES)) ? RES_CAP : res_u_q;
	assign rv = (32'(res_v_q) > 32'(MAX_RES)) ? RES_CAP : res_v_q;

	// pipe advances unless a finished result is held by the receiver
	logic en;
	logic vld_s [1:F4];

	assign en        = !(vld_s[F4] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_s[F4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= F4; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= F4; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// stage 1: capture the grid point
	logic [IDX_W-1:0] col_s1, row_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1 <= col_index;
			row_s1 <= row_index;
		end
	end

	// stage 2: range, face flag, wrapped neighbours and row products
	logic [RES_W-1:0] col_p1, row_p1, nc, nr;
	logic             rng_c, faces_c;

	always_comb begin
		col_p1  = RES_W'(col_s1) + 1'b1;
		row_p1  = RES_W'(row_s1) + 1'b1;
		rng_c   = (RES_W'(col_s1) < ru) && (RES_W'(row_s1) < rv);
		// plane quads stop before the last row and column; torus quads wrap
		nc      = (col_p1 == ru) ? '0 : col_p1;
		nr      = (row_p1 == rv) ? '0 : row_p1;
		faces_c = rng_c && ((mode_q == MODE_TORUS) || ((col_p1 < ru) && (row_p1 < rv)));
	end

	logic             rng_s2, faces_s2;
	logic [IDX_W-1:0] col_s2, row_s2;
	logic [RES_W-1:0] nc_s2;
	logic [15:0]      prow_s2, pnr_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			rng_s2   <= rng_c;
			faces_s2 <= faces_c;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			nc_s2    <= nc;
			prow_s2  <= 16'(row_s1 * ru);
			pnr_s2   <= 16'(nr * ru);
		end
	end

	// stage 3 on: index sums, then a delay line alongside the trig pipe
	tgv_side_t side_s [3:F3];

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[3].in_range <= rng_s2;
			side_s[3].faces    <= faces_s2;
			side_s[3].col      <= col_s2;
			side_s[3].row      <= row_s2;
			side_s[3].vidx     <= rng_s2 ? prow_s2 + 16'(col_s2) : '0;
			side_s[3].c_nc     <= faces_s2 ? prow_s2 + 16'(nc_s2) : '0;
			side_s[3].c_nr     <= faces_s2 ? pnr_s2 + 16'(col_s2) : '0;
			side_s[3].c_dg     <= faces_s2 ? pnr_s2 + 16'(nc_s2) : '0;
			for (int k = 4; k <= F3; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// phase of a turn for each axis
	logic [PH_W-1:0] phu, phv;

	tgv_phase_div u_div_u (
		.clk (clk),
		.en  (en),
		.num (col_s1),
		.den (ru),
		.quo (phu)
	);

	tgv_phase_div u_div_v (
		.clk (clk),
		.en  (en),
		.num (row_s1),
		.den (rv),
		.quo (phv)
	);

	// texture coordinates ride along from the divider output
	logic [15:0] texu_s [P_DIV+1:F3];
	logic [15:0] texv_s [P_DIV+1:F3];

	always_ff @(posedge clk) begin
		if (en) begin
			texu_s[P_DIV+1] <= phu[PH_W-1:PH_W-16];
			texv_s[P_DIV+1] <= phv[PH_W-1:PH_W-16];
			for (int k = P_DIV + 2; k <= F3; k++) begin
				texu_s[k] <= texu_s[k-1];
				texv_s[k] <= texv_s[k-1];
			end
		end
	end

	logic signed [SO_W-1:0] su, cu, sv, cv;

	tgv_sincos #(.TRIG_FRAC_BITS(T)) u_sc_u (
		.clk (clk),
		.en  (en),
		.ph  (phu),
		.sn  (su),
		.cs  (cu)
	);

	tgv_sincos #(.TRIG_FRAC_BITS(T)) u_sc_v (
		.clk (clk),
		.en  (en),
		.ph  (phv),
		.sn  (sv),
		.cs  (cv)
	);

	// F1: unrounded ring radius and tube height
	logic signed [RF_W-1:0] minor_sx;
	logic signed [RF_W-1:0] rf_f1, zp_f1;
	logic signed [SO_W-1:0] cu_f1, su_f1, cu_f2, su_f2;

	assign minor_sx = $signed(RF_W'(minor_q));

	always_ff @(posedge clk) begin
		if (en) begin
			rf_f1 <= $signed(RF_W'(major_q) << T) + minor_sx * RF_W'(cv);
			zp_f1 <= minor_sx * RF_W'(sv);
			cu_f1 <= cu;
			su_f1 <= su;
		end
	end

	// F2: round half away from zero
	logic signed [RF_W-1:0] rf_rnd, zp_rnd;
	logic signed [18:0]     ring_f2, zr_f2, zr_f3;

	always_comb begin
		rf_rnd = rf_f1 + (rf_f1[RF_W-1] ? RF_HALF - 1'b1 : RF_HALF);
		zp_rnd = zp_f1 + (zp_f1[RF_W-1] ? RF_HALF - 1'b1 : RF_HALF);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ring_f2 <= 19'(rf_rnd >>> T);
			zr_f2   <= 19'(zp_rnd >>> T);
			cu_f2   <= cu_f1;
			su_f2   <= su_f1;
		end
	end

	// F3: ring times the ring-angle cosine and sine
	logic signed [PX_W-1:0] px_f3, py_f3;

	always_ff @(posedge clk) begin
		if (en) begin
			px_f3 <= PX_W'(ring_f2) * PX_W'(cu_f2);
			py_f3 <= PX_W'(ring_f2) * PX_W'(su_f2);
			zr_f3 <= zr_f2;
		end
	end

	// F4: final rounding, saturation and mode selection into the output register
	logic signed [PX_W-1:0]  px_rnd, py_rnd;
	logic signed [POS_W-1:0] tx, ty, tz;
	tgv_side_t               sd;

	always_comb begin
		sd     = side_s[F3];
		px_rnd = px_f3 + (px_f3[PX_W-1] ? PX_HALF - 1'b1 : PX_HALF);
		py_rnd = py_f3 + (py_f3[PX_W-1] ? PX_HALF - 1'b1 : PX_HALF);
		tx     = sat_pos(21'(px_rnd >>> T));
		ty     = sat_pos(21'(py_rnd >>> T));
		tz     = sat_pos(21'(zr_f3));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_range        <= sd.in_range;
			vertex_index    <= sd.vidx;
			faces_valid     <= sd.faces;
			corner_here     <= sd.faces ? sd.vidx : '0;
			corner_next_col <= sd.c_nc;
			corner_next_row <= sd.c_nr;
			corner_diagonal <= sd.c_dg;
			if (!sd.in_range) begin
				pos_x <= '0;
				pos_y <= '0;
				pos_z <= '0;
				tex_u <= '0;
				tex_v <= '0;
			end else if (mode_q == MODE_TORUS) begin
				pos_x <= tx;
				pos_y <= ty;
				pos_z <= tz;
				tex_u <= texu_s[F3];
				tex_v <= texv_s[F3];
			end else begin
				pos_x <= $signed({2'b00, sd.col, 8'h00});
				pos_y <= $signed({2'b00, sd.row, 8'h00});
				pos_z <= '0;
				tex_u <= '0;
				tex_v <= '0;
			end
		end
	end

endmodule

### test/tb_torus_grid_vertex_and_face_gen_unit.sv
// testbench for the torus grid vertex and face generator: directed, random and stall tests
module tb_torus_grid_vertex_and_face_gen_unit
	import tgv_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TRIG = 14;
	localparam int MAXR = 256;
	localparam logic [4:0] ADDR_UNMAPPED = 5'd20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] col_index = '0;
	logic [7:0] row_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic in_range;
	logic [15:0] vertex_index;
	logic signed [17:0] pos_x, pos_y, pos_z;
	logic [15:0] tex_u, tex_v;
	logic faces_valid;
	logic [15:0] corner_here, corner_next_col, corner_next_row, corner_diagonal;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	torus_grid_vertex_and_face_gen_unit dut (.*);

	// vertex record expected from the block
	typedef struct {
		logic in_rng;
		logic [15:0] vidx;
		logic signed [17:0] px, py, pz;
		logic [15:0] tu, tv;
		logic faces;
		logic [15:0] ch, cnc, cnr, cdg;
	} vertex_t;

	vertex_t pending_vertices[$];
	int errors = 0;
	int sender_idle = 0;
	int receiver_idle = 0;
	int hold_off = 0;

	// shadow copy of the configuration registers
	mode_t shadow_mode;
	logic [15:0] shadow_major, shadow_minor;
	logic [8:0] shadow_res_u, shadow_res_v;

	always #10 clk = ~clk;

	// receiver stall: random, or a long forced hold-off when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_off > 0) begin
			out_stall <= 1'b1;
			hold_off = hold_off - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < receiver_idle);
		end
	end

	function automatic longint round_sh(input longint v);
		longint m, r;
		m = (v < 0) ? -v : v;
		r = (m + (longint'(1) <<< (TRIG - 1))) >>> TRIG;
		return (v < 0) ? -r : r;
	endfunction

	function automatic logic signed [17:0] clamp_pos(input longint v);
		if (v > 131071) v = 131071;
		if (v < -131072) v = -131072;
		return 18'(v);
	endfunction

	// octant folding plus truncated series, rounded to TRIG fraction bits
	function automatic void turn_sincos(input logic [31:0] ph, output longint sn,
		output longint cs);
		logic [63:0] one, r, x, x2, t, s, c, k;
		logic [1:0] q;
		bit swap;
		longint sq, cq;
		int sh;
		one = 64'd1 << 30;
		sh = 30 - TRIG;
		q = ph[31:30];
		r = 64'(ph[29:0]);
		swap = 0;
		if (r > (64'd1 << 29)) begin
			r = one - r;
			swap = 1;
		end
		x = (r * 64'(HALF_PI_Q30)) >> 30;
		x2 = (x * x) >> 30;
		t = one - x2 / 72;
		t = one - ((x2 * t) >> 30) / 42;
		t = one - ((x2 * t) >> 30) / 20;
		t = one - ((x2 * t) >> 30) / 6;
		s = (x * t) >> 30;
		t = one - x2 / 56;
		t = one - ((x2 * t) >> 30) / 30;
		t = one - ((x2 * t) >> 30) / 12;
		c = one - ((x2 * t) >> 30) / 2;
		s = (s + (64'd1 << (sh - 1))) >> sh;
		c = (c + (64'd1 << (sh - 1))) >> sh;
		if (swap) begin
			k = s; s = c; c = k;
		end
		sq = longint'(s);
		cq = longint'(c);
		case (q)
			2'd0: begin sn = sq; cs = cq; end
			2'd1: begin sn = cq; cs = -sq; end
			2'd2: begin sn = -sq; cs = -cq; end
			default: begin sn = -cq; cs = sq; end
		endcase
	endfunction

	// expected vertex, texture and quad corners for one grid point
	function automatic vertex_t grid_vertex(input logic [7:0] col, input logic [7:0] row);
		vertex_t v;
		logic [63:0] cu, rw, ru, rv, here, nc, nr;
		logic [31:0] phu, phv;
		longint su, cosu, sv, cosv, ring;
		v = '{default: '0};
		cu = 64'(col);
		rw = 64'(row);
		ru = (shadow_res_u > MAXR) ? MAXR : 64'(shadow_res_u);
		rv = (shadow_res_v > MAXR) ? MAXR : 64'(shadow_res_v);
		if (cu >= ru || rw >= rv) return v;
		here = rw * ru + cu;
		v.in_rng = 1'b1;
		v.vidx = here[15:0];
		if (shadow_mode == MODE_PLANE) begin
			v.px = clamp_pos(longint'(cu << 8));
			v.py = clamp_pos(longint'(rw << 8));
			if (cu + 1 < ru && rw + 1 < rv) begin
				v.faces = 1'b1;
				v.ch = here[15:0];
				v.cnc = 16'(here + 1);
				v.cnr = 16'(here + ru);
				v.cdg = 16'(here + ru + 1);
			end
		end else begin
			phu = 32'((cu << 32) / ru);
			phv = 32'((rw << 32) / rv);
			nc = (cu + 1 == ru) ? 0 : cu + 1;
			nr = (rw + 1 == rv) ? 0 : rw + 1;
			turn_sincos(phu, su, cosu);
			turn_sincos(phv, sv, cosv);
			ring = round_sh((longint'(shadow_major) <<< TRIG) + longint'(shadow_minor) * cosv);
			v.px = clamp_pos(round_sh(ring * cosu));
			v.py = clamp_pos(round_sh(ring * su));
			v.pz = clamp_pos(round_sh(longint'(shadow_minor) * sv));
			v.tu = phu[31:16];
			v.tv = phv[31:16];
			v.faces = 1'b1;
			v.ch = here[15:0];
			v.cnc = 16'(rw * ru + nc);
			v.cnr = 16'(nr * ru + cu);
			v.cdg = 16'(nr * ru + nc);
		end
		return v;
	endfunction

	// outputs are stable from the falling edge to the accepting rising edge
	always @(negedge clk) begin
		vertex_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_vertices.size() == 0) begin
				$error("unexpected result transaction, vertex_index %0d", vertex_index);
				errors++;
			end else begin
				e = pending_vertices.pop_front();
				if (in_range !== e.in_rng) begin
					$error("in_range exp %0d got %0d", e.in_rng, in_range); errors++;
				end
				if (vertex_index !== e.vidx) begin
					$error("vertex_index exp %0d got %0d", e.vidx, vertex_index); errors++;
				end
				if (pos_x !== e.px) begin
					$error("pos_x exp %0d got %0d", e.px, pos_x); errors++;
				end
				if (pos_y !== e.py) begin
					$error("pos_y exp %0d got %0d", e.py, pos_y); errors++;
				end
				if (pos_z !== e.pz) begin
					$error("pos_z exp %0d got %0d", e.pz, pos_z); errors++;
				end
				if (tex_u !== e.tu) begin
					$error("tex_u exp %0d got %0d", e.tu, tex_u); errors++;
				end
				if (tex_v !== e.tv) begin
					$error("tex_v exp %0d got %0d", e.tv, tex_v); errors++;
				end
				if (faces_valid !== e.faces) begin
					$error("faces_valid exp %0d got %0d", e.faces, faces_valid); errors++;
				end
				if (corner_here !== e.ch) begin
					$error("corner_here exp %0d got %0d", e.ch, corner_here); errors++;
				end
				if (corner_next_col !== e.cnc) begin
					$error("corner_next_col exp %0d got %0d", e.cnc, corner_next_col); errors++;
				end
				if (corner_next_row !== e.cnr) begin
					$error("corner_next_row exp %0d got %0d", e.cnr, corner_next_row); errors++;
				end
				if (corner_diagonal !== e.cdg) begin
					$error("corner_diagonal exp %0d got %0d", e.cdg, corner_diagonal); errors++;
				end
			end
		end
	end

	// offer one grid point, with random idle cycles ahead of it
	task automatic send_point(input logic [7:0] col, input logic [7:0] row);
		bit taken;
		while ($urandom_range(0, 99) < sender_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		col_index <= col;
		row_index <= row;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		pending_vertices.push_back(grid_vertex(col, row));
	endtask

	// wait for every outstanding result, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// apb write: setup cycle and access cycle, then the bus returns to idle
	task automatic reg_write(input logic [4:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (addr)
			5'(REG_MODE * 4): shadow_mode = mode_t'(data[0]);
			5'(REG_MAJOR * 4): shadow_major = data[15:0];
			5'(REG_MINOR * 4): shadow_minor = data[15:0];
			5'(REG_RES_U * 4): shadow_res_u = data[8:0];
			5'(REG_RES_V * 4): shadow_res_v = data[8:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input mode_t md, input logic [15:0] maj, input logic [15:0] mnr,
		input logic [8:0] ru, input logic [8:0] rv);
		drain();
		reg_write(5'(REG_MODE * 4), {31'($urandom), md});
		reg_write(5'(REG_MAJOR * 4), {16'($urandom), maj});
		reg_write(5'(REG_MINOR * 4), {16'($urandom), mnr});
		reg_write(5'(REG_RES_U * 4), {23'($urandom), ru});
		reg_write(5'(REG_RES_V * 4), {23'($urandom), rv});
	endtask

	// reset values: 16 x 16 torus, edges, wrap and out of range points
	task automatic test_reset_settings();
		send_point(8'd0, 8'd0);
		send_point(8'd15, 8'd15);
		send_point(8'd15, 8'd0);
		send_point(8'd0, 8'd15);
		send_point(8'd16, 8'd0);
		send_point(8'd0, 8'd16);
		send_point(8'd255, 8'd255);
		send_point(8'd4, 8'd12);
	endtask

	// plane grid: last row and column carry no quad, no texture
	task automatic test_plane_grid();
		set_config(MODE_PLANE, 16'd512, 16'd128, 9'd16, 9'd16);
		send_point(8'd0, 8'd0);
		send_point(8'd14, 8'd14);
		send_point(8'd15, 8'd3);
		send_point(8'd3, 8'd15);
		set_config(MODE_PLANE, 16'd0, 16'd0, 9'd256, 9'd256);
		send_point(8'd255, 8'd255);
		send_point(8'd254, 8'd254);
	endtask

	// radius and resolution extremes, including zero and clamped resolution
	task automatic test_extremes();
		set_config(MODE_TORUS, 16'hffff, 16'hffff, 9'd256, 9'd256);
		send_point(8'd255, 8'd255);
		send_point(8'd0, 8'd0);
		send_point(8'd64, 8'd128);
		send_point(8'd170, 8'd85);
		set_config(MODE_TORUS, 16'd0, 16'd0, 9'd1, 9'd1);
		send_point(8'd0, 8'd0);
		send_point(8'd1, 8'd0);
		set_config(MODE_TORUS, 16'd300, 16'd40, 9'd0, 9'd7);
		send_point(8'd0, 8'd0);
		set_config(MODE_TORUS, 16'd300, 16'd40, 9'd511, 9'd300);
		send_point(8'd255, 8'd255);
		send_point(8'd37, 8'd200);
		// write beyond the register map must change nothing
		drain();
		reg_write(ADDR_UNMAPPED, 32'hffff_ffff);
		send_point(8'd100, 8'd1);
	endtask

	// random settings per batch, mostly in-range points with some strays
	task automatic test_random_grid();
		logic [8:0] ru, rv;
		logic [7:0] c, r;
		int lim_u, lim_v;
		for (int batch = 0; batch < 19; batch++) begin
			if (batch == 0) begin
				sender_idle = 33; receiver_idle = 51;
			end else if (batch == 6) begin
				sender_idle = 51; receiver_idle = 33;
			end else if (batch == 12) begin
				sender_idle = 0; receiver_idle = 0;
			end
			case ($urandom_range(0, 3))
				0: ru = 9'd256;
				1: ru = 9'($urandom_range(1, 32));
				2: ru = 9'($urandom);
				default: ru = 9'($urandom_range(1, 256));
			endcase
			case ($urandom_range(0, 3))
				0: rv = 9'd256;
				1: rv = 9'($urandom_range(1, 32));
				2: rv = 9'($urandom);
				default: rv = 9'($urandom_range(1, 256));
			endcase
			set_config(mode_t'($urandom_range(0, 1)),
				($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom),
				($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom_range(0, 4095)),
				ru, rv);
			lim_u = (ru == 0) ? 0 : ((ru > MAXR) ? MAXR - 1 : ru - 1);
			lim_v = (rv == 0) ? 0 : ((rv > MAXR) ? MAXR - 1 : rv - 1);
			for (int i = 0; i < 100; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					c = 8'($urandom);
					r = 8'($urandom);
				end else begin
					c = 8'($urandom_range(0, lim_u));
					r = 8'($urandom_range(0, lim_v));
				end
				send_point(c, r);
			end
		end
	endtask

	// long receiver hold-off fills the pipeline and forces the input to stall
	task automatic test_backpressure();
		set_config(MODE_TORUS, 16'd900, 16'd300, 9'd24, 9'd12);
		sender_idle = 0;
		receiver_idle = 0;
		hold_off = 300;
		for (int i = 0; i < 80; i++) send_point(8'($urandom_range(0, 23)), 8'($urandom_range(0, 11)));
		// sender pauses until every result is back
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_vertices.size() != 0) @(posedge clk);
		receiver_idle = 40;
		for (int i = 0; i < 20; i++) send_point(8'($urandom_range(0, 23)), 8'($urandom_range(0, 11)));
	endtask

	initial begin
		shadow_mode = MODE_TORUS;
		shadow_major = MAJOR_RST;
		shadow_minor = MINOR_RST;
		shadow_res_u = RES_RST;
		shadow_res_v = RES_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_settings();
		test_plane_grid();
		test_extremes();
		test_random_grid();
		test_backpressure();
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
